/* src/tmbc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the tile map box collision block.
// No dependencies; imported by every other file except tmbc_ram.
package tmbc_pkg;

    // Fixed field widths.
    localparam int POS_W  = 24;
    localparam int SIZE_W = 16;
    localparam int VEL_W  = 16;
    localparam int TS_W   = 9;
    localparam int MASK_W = 64;
    localparam int CFG_IDX_W = 1;

    // Internal widths: a moved position and a far edge.
    localparam int XW  = 25;
    localparam int EW  = 26;
    // Pixel coordinate (four fraction bits dropped) and its magnitude.
    localparam int QW  = EW - 4;
    localparam int UW  = QW - 1;
    localparam int REM_W = TS_W + 1;
    localparam int CNT_W = $clog2(UW + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_EDGE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOLID_MASK = 1'd1;

    // Division operand select.
    localparam logic [1:0] SEL_C0 = 2'd0;
    localparam logic [1:0] SEL_C1 = 2'd1;
    localparam logic [1:0] SEL_R0 = 2'd2;
    localparam logic [1:0] SEL_R1 = 2'd3;

    typedef struct packed {
        logic       take;
        logic       clr;
        logic       y_move;
        logic       axis;
        logic [1:0] div_sel;
        logic       div_start;
        logic       div_store;
        logic       scan_init;
        logic       scan_next;
        logic       snap_mul;
        logic       snap_apply;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic ts_zero;
        logic vx_zero;
        logic vy_zero;
        logic div_done;
        logic empty;
        logic solid;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

/* src/tile_map_box_collision.sv */
`timescale 1ns / 1ps
// Top level of the tile map box collision block.
// Depends on tmbc_pkg, tmbc_ctrl and tmbc_dp (which holds tmbc_div and tmbc_ram).
//
// Usage: items arrive on the input channel (i_in_valid / o_in_stall). An item
// with i_action low writes one tile id into the map and produces no result.
// An item with i_action high moves a box along x, then along y, and produces
// one result transaction on the output channel (o_out_valid / i_out_stall).
// Configuration (tile size, solid mask) is written through i_cfg_we, i_cfg_index
// and i_cfg_data; the user writes it only while the block is idle (not enforced).
//
// Throughput: one item at a time. A tile write is taken in the idle state. A
// move has a dispatch step and an output load step, plus for each axis with
// nonzero velocity a scan setup and wrap-up and four divisions on the shared
// one-bit-per-cycle divider, plus one registered memory read and a check per
// scanned map cell, plus a multiply and an apply step when a solid cell is
// hit. A zero tile size skips both axes. The result is valid on the cycle
// after the output load. The output register lets the next item be accepted
// while a result waits; a stalled receiver holds the result and blocks only
// the handoff of the next one.
//
// Reset: synchronous, active low. After reset the block clears the map with
// one write per cycle over all MAP_COLS*MAP_ROWS cells (4096 by default) and
// stalls its input during that pass.
module tile_map_box_collision
    import tmbc_pkg::*;
#(
    parameter int MAP_COLS     = 64,
    parameter int MAP_ROWS     = 64,
    parameter int TILE_ID_BITS = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [MASK_W-1:0]        i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_action,
    input  logic [5:0]               i_tile_col,
    input  logic [5:0]               i_tile_row,
    input  logic [5:0]               i_tile_value,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic [SIZE_W-1:0]        i_size_w,
    input  logic [SIZE_W-1:0]        i_size_h,
    input  logic signed [VEL_W-1:0]  i_vel_x,
    input  logic signed [VEL_W-1:0]  i_vel_y,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [POS_W-1:0]  o_new_x,
    output logic signed [POS_W-1:0]  o_new_y,
    output logic signed [VEL_W-1:0]  o_new_vel_x,
    output logic signed [VEL_W-1:0]  o_new_vel_y,
    output logic                     o_hit_x,
    output logic                     o_hit_y
);

    t_cmd cmd;
    t_sts sts;

    // The controller sequences every step; config writes go direct to the datapath.
    tmbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    tmbc_dp #(
        .MAP_COLS     (MAP_COLS),
        .MAP_ROWS     (MAP_ROWS),
        .TILE_ID_BITS (TILE_ID_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_action     (i_action),
        .i_tile_col   (i_tile_col),
        .i_tile_row   (i_tile_row),
        .i_tile_value (i_tile_value),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_size_w     (i_size_w),
        .i_size_h     (i_size_h),
        .i_vel_x      (i_vel_x),
        .i_vel_y      (i_vel_y),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_new_x      (o_new_x),
        .o_new_y      (o_new_y),
        .o_new_vel_x  (o_new_vel_x),
        .o_new_vel_y  (o_new_vel_y),
        .o_hit_x      (o_hit_x),
        .o_hit_y      (o_hit_y)
    );

endmodule

/* src/tmbc_ram.sv */
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tmbc_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/tmbc_div.sv */
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tmbc_pkg for operand widths.
module tmbc_div
    import tmbc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [UW-1:0]    i_dividend,
    input  logic [TS_W-1:0]  i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [UW-1:0]    o_quotient
);

    logic [UW-1:0]    r_acc;
    logic [REM_W-1:0] r_rem;
    logic [TS_W-1:0]  r_dsr;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [REM_W-1:0] trial;
    logic             qbit;

    assign trial = {r_rem[REM_W-2:0], r_acc[UW-1]};
    assign qbit  = (trial >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(UW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_acc <= {r_acc[UW-2:0], qbit};
            r_rem <= qbit ? (trial - {1'b0, r_dsr}) : trial;
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_acc;

endmodule

/* src/tmbc_dp.sv */
`timescale 1ns / 1ps
// Datapath: configuration, item registers, cell index division, map scan and snap.
// Depends on tmbc_pkg, tmbc_div and tmbc_ram.
module tmbc_dp
    import tmbc_pkg::*;
#(
    parameter int MAP_COLS     = 64,
    parameter int MAP_ROWS     = 64,
    parameter int TILE_ID_BITS = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [MASK_W-1:0]        i_cfg_data,
    input  logic                     i_action,
    input  logic [5:0]               i_tile_col,
    input  logic [5:0]               i_tile_row,
    input  logic [5:0]               i_tile_value,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic [SIZE_W-1:0]        i_size_w,
    input  logic [SIZE_W-1:0]        i_size_h,
    input  logic signed [VEL_W-1:0]  i_vel_x,
    input  logic signed [VEL_W-1:0]  i_vel_y,
    input  logic                     i_out_stall,
    output logic                     o_out_valid,
    output logic signed [POS_W-1:0]  o_new_x,
    output logic signed [POS_W-1:0]  o_new_y,
    output logic signed [VEL_W-1:0]  o_new_vel_x,
    output logic signed [VEL_W-1:0]  o_new_vel_y,
    output logic                     o_hit_x,
    output logic                     o_hit_y
);

    localparam int DEPTH = MAP_COLS * MAP_ROWS;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;
    localparam int RW = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
    localparam int IW = (CW > RW) ? CW : RW;
    localparam int PW = IW + TS_W;

    logic [TS_W-1:0]   r_ts;
    logic [MASK_W-1:0] r_mask;
    logic signed [XW-1:0] r_x, r_y;
    logic [SIZE_W-1:0] r_w, r_h;
    logic signed [VEL_W-1:0] r_vx, r_vy;
    logic r_hx, r_hy;
    logic signed [QW-1:0] r_c0, r_c1, r_r0, r_r1;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [PW-1:0] r_prod;
    logic          r_neg;
    logic [AW-1:0] r_clr_addr;

    logic r_out_valid;
    logic signed [POS_W-1:0] r_out_x, r_out_y;
    logic signed [VEL_W-1:0] r_out_vx, r_out_vy;
    logic r_out_hx, r_out_hy;

    logic signed [EW-1:0] dvd;
    logic signed [QW-1:0] pix;
    logic [UW-1:0]        mag;
    logic                 div_busy, div_done;
    logic [UW-1:0]        quo;
    logic signed [QW-1:0] q_s;
    logic                 wr_in_map;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [TILE_ID_BITS-1:0] ram_wdata, ram_rdata;
    logic signed [EW-1:0] base, span, snap_lo, snap_hi;
    logic                 out_take;

    // Operand for the four cell index divisions.
    always_comb begin
        case (i_cmd.div_sel)
            SEL_C0:  dvd = EW'(r_x);
            SEL_C1:  dvd = EW'(r_x) + EW'(signed'({1'b0, r_w})) - EW'(1);
            SEL_R0:  dvd = EW'(r_y);
            SEL_R1:  dvd = EW'(r_y) + EW'(signed'({1'b0, r_h})) - EW'(1);
            default: dvd = EW'(r_x);
        endcase
    end

    // Floor division by the tile edge times 16: drop the fraction, then floor
    // by the tile edge. For a negative value floor(a/d) = ~(~a / d).
    assign pix = dvd[EW-1:4];
    assign mag = pix[QW-1] ? ~pix[UW-1:0] : pix[UW-1:0];
    assign q_s = r_neg ? ~signed'({1'b0, quo}) : signed'({1'b0, quo});

    tmbc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (mag),
        .i_divisor  (r_ts),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    assign wr_in_map = (32'(i_tile_col) < 32'(MAP_COLS)) && (32'(i_tile_row) < 32'(MAP_ROWS));
    assign ram_we    = i_cmd.clr || (i_cmd.take && !i_action && wr_in_map);
    assign ram_waddr = i_cmd.clr ? r_clr_addr
                     : AW'(32'(i_tile_row) * 32'(MAP_COLS) + 32'(i_tile_col));
    assign ram_wdata = i_cmd.clr ? '0 : i_tile_value[TILE_ID_BITS-1:0];
    assign ram_raddr = AW'(32'(r_row) * 32'(MAP_COLS) + 32'(r_col));

    tmbc_ram #(
        .WIDTH (TILE_ID_BITS),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign base    = EW'(signed'({1'b0, r_prod, 4'b0000}));
    assign span    = EW'(signed'({1'b0, r_ts, 4'b0000}));
    assign snap_lo = base - EW'(signed'({1'b0, i_cmd.axis ? r_h : r_w}));
    assign snap_hi = base + span;
    assign out_take = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts       <= TS_W'(16);
            r_mask     <= '0;
            r_clr_addr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TILE_EDGE:  r_ts   <= i_cfg_data[TS_W-1:0];
                    CFG_SOLID_MASK: r_mask <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_action) begin
            // A zero tile edge leaves the box where it was.
            r_x  <= (r_ts == '0) ? XW'(i_pos_x) : XW'(i_pos_x) + XW'(i_vel_x);
            r_y  <= XW'(i_pos_y);
            r_w  <= i_size_w;
            r_h  <= i_size_h;
            r_vx <= i_vel_x;
            r_vy <= i_vel_y;
            r_hx <= 1'b0;
            r_hy <= 1'b0;
        end
        if (i_cmd.y_move) begin
            r_y <= r_y + XW'(r_vy);
        end
        if (i_cmd.div_start) begin
            r_neg <= pix[QW-1];
        end
        if (i_cmd.div_store) begin
            case (i_cmd.div_sel)
                SEL_C0:  r_c0 <= q_s[QW-1] ? '0 : q_s;
                SEL_C1:  r_c1 <= (q_s > QW'(MAP_COLS - 1)) ? QW'(MAP_COLS - 1) : q_s;
                SEL_R0:  r_r0 <= q_s[QW-1] ? '0 : q_s;
                SEL_R1:  r_r1 <= (q_s > QW'(MAP_ROWS - 1)) ? QW'(MAP_ROWS - 1) : q_s;
                default: ;
            endcase
        end
        if (i_cmd.scan_init) begin
            r_col <= r_c0[CW-1:0];
            r_row <= r_r0[RW-1:0];
        end else if (i_cmd.scan_next) begin
            if (r_col == r_c1[CW-1:0]) begin
                r_col <= r_c0[CW-1:0];
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
        if (i_cmd.snap_mul) begin
            r_prod <= PW'(i_cmd.axis ? IW'(r_row) : IW'(r_col)) * PW'(r_ts);
        end
        if (i_cmd.snap_apply) begin
            if (!i_cmd.axis) begin
                r_x  <= (r_vx > 0) ? XW'(snap_lo) : XW'(snap_hi);
                r_vx <= '0;
                r_hx <= 1'b1;
            end else begin
                r_y  <= (r_vy > 0) ? XW'(snap_lo) : XW'(snap_hi);
                r_vy <= '0;
                r_hy <= 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            r_out_x  <= (r_x[XW-1] != r_x[XW-2])
                      ? {r_x[XW-1], {(POS_W-1){~r_x[XW-1]}}} : r_x[POS_W-1:0];
            r_out_y  <= (r_y[XW-1] != r_y[XW-2])
                      ? {r_y[XW-1], {(POS_W-1){~r_y[XW-1]}}} : r_y[POS_W-1:0];
            r_out_vx <= r_vx;
            r_out_vy <= r_vy;
            r_out_hx <= r_hx;
            r_out_hy <= r_hy;
        end
    end

    always_comb begin
        o_sts.clr_last  = (r_clr_addr == AW'(DEPTH - 1));
        o_sts.ts_zero   = (r_ts == '0);
        o_sts.vx_zero   = (r_vx == '0);
        o_sts.vy_zero   = (r_vy == '0);
        o_sts.div_done  = div_done;
        o_sts.empty     = (r_c0 > r_c1) || (r_r0 > r_r1);
        o_sts.solid     = r_mask[6'(ram_rdata)];
        o_sts.scan_last = (r_col == r_c1[CW-1:0]) && (r_row == r_r1[RW-1:0]);
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_new_x     = r_out_x;
    assign o_new_y     = r_out_y;
    assign o_new_vel_x = r_out_vx;
    assign o_new_vel_y = r_out_vy;
    assign o_hit_x     = r_out_hx;
    assign o_hit_y     = r_out_hy;

    a_hitx_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_hx |-> r_out_vx == '0)
        else $error("x hit reported with nonzero x velocity");
    a_hity_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_hy |-> r_out_vy == '0)
        else $error("y hit reported with nonzero y velocity");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !div_busy)
        else $error("divider restarted while busy");
    a_snap_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.snap_apply |-> $past(i_cmd.snap_mul))
        else $error("snap applied without product");

endmodule

/* src/tmbc_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine sequencing clear, divisions, map scan and snap.
// Depends on tmbc_pkg.
module tmbc_ctrl
    import tmbc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_action,
    input  t_sts i_sts,
    output logic o_in_stall,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_DGO   = 4'd3;
    localparam logic [3:0] S_DWAIT = 4'd4;
    localparam logic [3:0] S_SINIT = 4'd5;
    localparam logic [3:0] S_SRD   = 4'd6;
    localparam logic [3:0] S_SCHK  = 4'd7;
    localparam logic [3:0] S_SMUL  = 4'd8;
    localparam logic [3:0] S_SSET  = 4'd9;
    localparam logic [3:0] S_AEND  = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_axis, n_axis;
    logic [1:0] r_sel, n_sel;

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.axis    = r_axis;
        o_cmd.div_sel = r_sel;
        o_in_stall    = (r_state != S_IDLE);
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.take = i_in_valid;
                if (i_in_valid && i_action) n_state = S_DISP;
            end
            S_DISP: begin
                n_sel = SEL_C0;
                if (i_sts.ts_zero) begin
                    n_state = S_FIN;
                end else if (!i_sts.vx_zero) begin
                    n_axis  = 1'b0;
                    n_state = S_DGO;
                end else if (!i_sts.vy_zero) begin
                    n_axis       = 1'b1;
                    o_cmd.y_move = 1'b1;
                    n_state      = S_DGO;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DGO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.div_store = 1'b1;
                    if (r_sel == SEL_R1) begin
                        n_state = S_SINIT;
                    end else begin
                        n_sel   = r_sel + 2'd1;
                        n_state = S_DGO;
                    end
                end
            end
            S_SINIT: begin
                o_cmd.scan_init = 1'b1;
                n_state = i_sts.empty ? S_AEND : S_SRD;
            end
            S_SRD: begin
                n_state = S_SCHK;
            end
            S_SCHK: begin
                if (i_sts.solid) begin
                    n_state = S_SMUL;
                end else if (i_sts.scan_last) begin
                    n_state = S_AEND;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state = S_SRD;
                end
            end
            S_SMUL: begin
                o_cmd.snap_mul = 1'b1;
                n_state = S_SSET;
            end
            S_SSET: begin
                o_cmd.snap_apply = 1'b1;
                n_state = S_AEND;
            end
            S_AEND: begin
                n_sel = SEL_C0;
                if (!r_axis && !i_sts.vy_zero) begin
                    n_axis       = 1'b1;
                    o_cmd.y_move = 1'b1;
                    n_state      = S_DGO;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_axis  <= 1'b0;
            r_sel   <= SEL_C0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_sel   <= n_sel;
        end
    end

endmodule
